FILE: rtl/extent_bisection_partitioner_core_defines.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef EXTENT_BISECTION_PARTITIONER_CORE_DEFINES_SVH
`define EXTENT_BISECTION_PARTITIONER_CORE_DEFINES_SVH

`define EBP_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ebp: same-cycle property failed");

`define EBP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ebp: next-cycle property failed");

`endif

FILE: rtl/ebp_pkg.sv
package ebp_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_FEW = 2'd1;
  localparam status_t ST_INV = 2'd2;

  typedef struct packed {
    logic    load;
    logic    clamp;
    logic    mul1;
    logic    mul2;
    logic    init;
    logic    next_axis;
    logic    pass_start;
    logic    pop;
    logic    split;
    logic    push_low;
    logic    emit_start;
    logic    emit_read;
    logic    emit_next;
    logic    part_load;
    logic    err_load;
    status_t err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic inverted;
    logic few;
    logic fill_done;
    logic axis_on;
    logic pass_done;
    logic push_done;
    logic out_last;
  } dp_sts_t;

endpackage

FILE: rtl/ebp_in_if.sv
interface ebp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_low;
  logic [15:0] x_high;
  logic [15:0] y_low;
  logic [15:0] y_high;
  logic [15:0] z_low;
  logic [15:0] z_high;
  logic [6:0]  block_count;

  modport source (output valid, x_low, x_high, y_low, y_high, z_low, z_high, block_count,
                  input ready);
  modport sink (input valid, x_low, x_high, y_low, y_high, z_low, z_high, block_count,
                output ready);
endinterface

FILE: rtl/ebp_out_if.sv
interface ebp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] part_x_low;
  logic [15:0] part_x_high;
  logic [15:0] part_y_low;
  logic [15:0] part_y_high;
  logic [15:0] part_z_low;
  logic [15:0] part_z_high;
  logic [5:0]  part_number;
  logic [1:0]  status;
  logic        last_part;

  modport source (output valid, part_x_low, part_x_high, part_y_low, part_y_high,
                  part_z_low, part_z_high, part_number, status, last_part,
                  input ready);
  modport sink (input valid, part_x_low, part_x_high, part_y_low, part_y_high,
                part_z_low, part_z_high, part_number, status, last_part,
                output ready);
endinterface

FILE: rtl/extent_bisection_partitioner_core.sv
// Splits one inclusive 3D index extent into block_count disjoint blocks (a
// block_count of 0 is taken as 1 and one above MAX_BLOCKS as MAX_BLOCKS) by
// repeated halving along the axes that are longer than one cell, and returns
// one item per block in final queue order with last_part set on the final one.
// A request with a low bound above its high bound, or with fewer cells than
// blocks, returns a single item carrying the error status. Requests are handled
// one at a time. After acceptance the bounds are checked and the cell count is
// formed and compared, then each block taken from the work queue is read, its
// upper half written and its lower half written in separate steps because the
// queue memory has one write port; a block too short on the pass axis is
// written back whole. Each axis pass and each skipped axis take a step of
// their own, and each result is read, registered and held until accepted.
module extent_bisection_partitioner_core #(
  parameter int MAX_BLOCKS = 64,
  parameter int COORD_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  ebp_in_if.sink    in_ch,
  ebp_out_if.source out_ch
);
  import ebp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ebp_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ebp_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .x_low       (in_ch.x_low),
    .x_high      (in_ch.x_high),
    .y_low       (in_ch.y_low),
    .y_high      (in_ch.y_high),
    .z_low       (in_ch.z_low),
    .z_high      (in_ch.z_high),
    .block_count (in_ch.block_count),
    .part_x_low  (out_ch.part_x_low),
    .part_x_high (out_ch.part_x_high),
    .part_y_low  (out_ch.part_y_low),
    .part_y_high (out_ch.part_y_high),
    .part_z_low  (out_ch.part_z_low),
    .part_z_high (out_ch.part_z_high),
    .part_number (out_ch.part_number),
    .status      (out_ch.status),
    .last_part   (out_ch.last_part)
  );

endmodule

FILE: rtl/ebp_controller.sv
module ebp_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ebp_pkg::dp_sts_t  sts,
  output ebp_pkg::dp_cmd_t  cmd
);
  import ebp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL1, S_MUL2, S_CMP, S_PASS, S_POP, S_SPLIT, S_PUSHL,
    S_EREAD, S_EWAIT, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    cmd.err_code = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.inverted) begin
          cmd.err_load = 1'b1;
          cmd.err_code = ST_INV;
          state_next = S_OUT;
        end else begin
          cmd.clamp = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.few) begin
          cmd.err_load = 1'b1;
          cmd.err_code = ST_FEW;
          state_next = S_OUT;
        end else begin
          cmd.init = 1'b1;
          state_next = S_PASS;
        end
      end
      S_PASS: begin
        if (sts.fill_done) begin
          cmd.emit_start = 1'b1;
          state_next = S_EREAD;
        end else if (!sts.axis_on) begin
          cmd.next_axis = 1'b1;
        end else begin
          cmd.pass_start = 1'b1;
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        state_next = S_PUSHL;
      end
      S_PUSHL: begin
        cmd.push_low = 1'b1;
        if (sts.push_done) begin
          cmd.emit_start = 1'b1;
          state_next = S_EREAD;
        end else if (sts.pass_done) begin
          cmd.next_axis = 1'b1;
          state_next = S_PASS;
        end else begin
          state_next = S_POP;
        end
      end
      S_EREAD: begin
        cmd.emit_read = 1'b1;
        state_next = S_EWAIT;
      end
      S_EWAIT: begin
        cmd.part_load = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (sts.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next = S_EREAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_ready <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      in_ready <= (state_next == S_IDLE);
      out_valid <= (state_next == S_OUT);
    end
  end

endmodule

FILE: rtl/ebp_datapath.sv
module ebp_datapath #(
  parameter int MAX_BLOCKS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  ebp_pkg::dp_cmd_t cmd,
  output ebp_pkg::dp_sts_t sts,
  input  logic [15:0]      x_low,
  input  logic [15:0]      x_high,
  input  logic [15:0]      y_low,
  input  logic [15:0]      y_high,
  input  logic [15:0]      z_low,
  input  logic [15:0]      z_high,
  input  logic [6:0]       block_count,
  output logic [15:0]      part_x_low,
  output logic [15:0]      part_x_high,
  output logic [15:0]      part_y_low,
  output logic [15:0]      part_y_high,
  output logic [15:0]      part_z_low,
  output logic [15:0]      part_z_high,
  output logic [5:0]       part_number,
  output logic [1:0]       status,
  output logic             last_part
);
  import ebp_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  typedef logic [2:0][CB-1:0] corner_t;

  corner_t           mem_lo [MAX_BLOCKS];
  corner_t           mem_hi [MAX_BLOCKS];
  corner_t           in_lo;
  corner_t           in_hi;
  corner_t           rd_lo;
  corner_t           rd_hi;
  corner_t           low_lo;
  corner_t           low_hi;
  corner_t           up_lo;
  corner_t           lw_hi;
  corner_t           wr_lo;
  corner_t           wr_hi;
  logic [2:0][CW-1:0] clen;
  logic [CW-1:0]     count;
  logic [CW-1:0]     prod;
  logic              few;
  logic [2:0]        mask;
  logic [1:0]        axis;
  logic [AW-1:0]     head;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     rem;
  logic [CW-1:0]     k;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic              can_split;
  logic [CB:0]       ni;
  logic [CB-1:0]     half;
  logic [2*CW-1:0]   p1;
  logic [2*CW-1:0]   p2;
  logic [CB+15:0]    ext_in [6];
  logic [CB+15:0]    ext_out [6];
  logic [CW+5:0]     k_ext;
  logic [15:0]       raw [6];

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(MAX_BLOCKS)) begin
      s = s - (CW+1)'(MAX_BLOCKS);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] clamp_len(input logic [CB-1:0] lo, input logic [CB-1:0] hi);
    logic [CB:0] l;
    l = (CB+1)'(hi) - (CB+1)'(lo) + (CB+1)'(1);
    if (l > MAX_BLOCKS) begin
      return CW'(MAX_BLOCKS);
    end
    return CW'(l);
  endfunction

  assign raw[0] = x_low;
  assign raw[1] = x_high;
  assign raw[2] = y_low;
  assign raw[3] = y_high;
  assign raw[4] = z_low;
  assign raw[5] = z_high;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ext_in[i] = (CB+16)'(raw[i]);
    end
  end

  assign can_split = rd_hi[axis] != rd_lo[axis];
  assign ni = (CB+1)'(rd_hi[axis]) - (CB+1)'(rd_lo[axis]) + (CB+1)'(1);
  assign half = ni[CB:1];

  always_comb begin
    up_lo = rd_lo;
    up_lo[axis] = rd_lo[axis] + half;
    lw_hi = rd_hi;
    if (can_split) begin
      lw_hi[axis] = rd_lo[axis] + half - CB'(1);
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = slot_of(head, fill);
    wr_lo = low_lo;
    wr_hi = low_hi;
    if (cmd.init) begin
      wr_en = 1'b1;
      wr_addr = '0;
      wr_lo = in_lo;
      wr_hi = in_hi;
    end else if (cmd.split && can_split) begin
      wr_en = 1'b1;
      wr_lo = up_lo;
      wr_hi = rd_hi;
    end else if (cmd.push_low) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = cmd.pop ? head : slot_of(head, k);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo[wr_addr] <= wr_lo;
      mem_hi[wr_addr] <= wr_hi;
    end
    if (cmd.pop || cmd.emit_read) begin
      rd_lo <= mem_lo[rd_addr];
      rd_hi <= mem_hi[rd_addr];
    end
  end

  assign p1 = (2*CW)'(clen[0]) * (2*CW)'(clen[1]);
  assign p2 = (2*CW)'(prod) * (2*CW)'(clen[2]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) begin
        in_lo[a] <= ext_in[2*a][CB-1:0];
        in_hi[a] <= ext_in[2*a+1][CB-1:0];
      end
      if (block_count == 7'd0) begin
        count <= CW'(1);
      end else if (block_count > MAX_BLOCKS) begin
        count <= CW'(MAX_BLOCKS);
      end else begin
        count <= CW'(block_count);
      end
    end
    if (cmd.clamp) begin
      for (int a = 0; a < 3; a++) begin
        clen[a] <= clamp_len(in_lo[a], in_hi[a]);
      end
    end
    if (cmd.mul1) begin
      prod <= (p1 > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(p1);
    end
    if (cmd.mul2) begin
      few <= p2 < (2*CW)'(count);
    end
    if (cmd.split) begin
      low_lo <= rd_lo;
      low_hi <= lw_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      axis <= '0;
      head <= '0;
      fill <= '0;
      rem <= '0;
      k <= '0;
    end else begin
      if (cmd.init) begin
        head <= '0;
        fill <= CW'(1);
        axis <= '0;
        for (int a = 0; a < 3; a++) begin
          mask[a] <= in_hi[a] != in_lo[a];
        end
      end
      if (cmd.next_axis) begin
        axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
      end
      if (cmd.pass_start) begin
        rem <= fill;
      end
      if (cmd.pop) begin
        head <= slot_of(head, CW'(1));
        fill <= fill - CW'(1);
        rem <= rem - CW'(1);
      end
      if ((cmd.split && can_split) || cmd.push_low) begin
        fill <= fill + CW'(1);
      end
      if (cmd.emit_start) begin
        k <= '0;
      end
      if (cmd.emit_next) begin
        k <= k + CW'(1);
      end
    end
  end

  assign k_ext = (CW+6)'(k);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext_out[2*a] = (CB+16)'(rd_lo[a]);
      ext_out[2*a+1] = (CB+16)'(rd_hi[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.part_load) begin
      part_x_low <= ext_out[0][15:0];
      part_x_high <= ext_out[1][15:0];
      part_y_low <= ext_out[2][15:0];
      part_y_high <= ext_out[3][15:0];
      part_z_low <= ext_out[4][15:0];
      part_z_high <= ext_out[5][15:0];
      part_number <= k_ext[5:0];
      status <= ST_OK;
      last_part <= (CW+1)'(k) + (CW+1)'(1) == (CW+1)'(fill);
    end else if (cmd.err_load) begin
      part_x_low <= '0;
      part_x_high <= '0;
      part_y_low <= '0;
      part_y_high <= '0;
      part_z_low <= '0;
      part_z_high <= '0;
      part_number <= '0;
      status <= cmd.err_code;
      last_part <= 1'b1;
    end
  end

  always_comb begin
    sts.inverted = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (in_lo[a] > in_hi[a]) begin
        sts.inverted = 1'b1;
      end
    end
    sts.few = few;
    sts.fill_done = fill == count;
    sts.axis_on = mask[axis];
    sts.pass_done = rem == '0;
    sts.push_done = (CW+1)'(fill) + (CW+1)'(1) == (CW+1)'(count);
    sts.out_last = last_part;
  end

endmodule

FILE: rtl/ebp_checker.sv
`include "extent_bisection_partitioner_core_defines.svh"

module ebp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] part_x_low,
  input logic [1:0]  status,
  input logic        last_part
);
  import ebp_pkg::*;

  `EBP_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(part_x_low) && $stable(status))
  `EBP_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `EBP_IMPLY(a_err_is_last, out_valid && status != ST_OK, last_part)
  `EBP_IMPLY(a_no_accept_while_out, out_valid, !in_ready)

endmodule

bind extent_bisection_partitioner_core ebp_checker u_ebp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .part_x_low (out_ch.part_x_low),
  .status     (out_ch.status),
  .last_part  (out_ch.last_part)
);

FILE: bench/extent_bisection_partitioner_core_checker.sv
`timescale 1ns / 1ps

module extent_bisection_partitioner_core_checker (
  input  logic      clk,
  input  logic      rst,
  ebp_in_if         in_ch,
  ebp_out_if        out_ch,
  output int        fail_count,
  output int        pending_parts,
  output int        parts_seen,
  output int        errors_seen
);
  import ebp_pkg::*;

  typedef struct packed {
    logic [15:0] xl, xh, yl, yh, zl, zh;
    logic [5:0]  num;
    status_t     st;
    logic        last;
  } block_part_t;

  block_part_t expected_parts[$];

  function automatic void expect_part(block_part_t p);
    expected_parts.insert(expected_parts.size(), p);
  endfunction

  function automatic void push_block(ref logic [15:0] qlo[64][3], ref logic [15:0] qhi[64][3],
                                     input int head, inout int fill,
                                     input logic [15:0] lo[3], input logic [15:0] hi[3]);
    int s;
    s = (head + fill) % 64;
    qlo[s] = lo;
    qhi[s] = hi;
    fill++;
  endfunction

  task automatic bisect_extent(input logic [15:0] lo[3], input logic [15:0] hi[3],
                               input logic [6:0] bc);
    logic [15:0] qlo[64][3];
    logic [15:0] qhi[64][3];
    logic [15:0] blo[3], bhi[3], ulo[3], uhi[3];
    longint len[3];
    longint cells, ni, half;
    int count, head, fill, remaining, s;
    logic [2:0] axes;
    block_part_t p;
    bit finished;
    count = bc;
    cells = 1;
    head = 0;
    fill = 0;
    axes = '0;
    finished = 0;
    if (count == 0) count = 1;
    if (count > 64) count = 64;
    p = '0;
    p.last = 1'b1;
    if (lo[0] > hi[0] || lo[1] > hi[1] || lo[2] > hi[2]) begin
      p.st = ST_INV;
      expect_part(p);
      return;
    end
    for (int a = 0; a < 3; a++) begin
      len[a] = longint'(hi[a]) - longint'(lo[a]) + 1;
      cells *= (len[a] > 1048576) ? 1048576 : len[a];
      if (len[a] > 1) axes[a] = 1'b1;
    end
    if (cells < count) begin
      p.st = ST_FEW;
      expect_part(p);
      return;
    end
    push_block(qlo, qhi, head, fill, lo, hi);
    while (fill < count && !finished) begin
      for (int ax = 0; ax < 3 && !finished; ax++) begin
        if (!axes[ax]) continue;
        remaining = fill;
        while (remaining > 0 && !finished) begin
          blo = qlo[head];
          bhi = qhi[head];
          head = (head + 1) % 64;
          fill--;
          remaining--;
          ni = longint'(bhi[ax]) - longint'(blo[ax]) + 1;
          if (ni >= 2) begin
            half = ni / 2;
            ulo = blo;
            uhi = bhi;
            ulo[ax] = blo[ax] + 16'(half);
            bhi[ax] = blo[ax] + 16'(half) - 16'd1;
            push_block(qlo, qhi, head, fill, ulo, uhi);
          end
          push_block(qlo, qhi, head, fill, blo, bhi);
          if (fill == count) finished = 1;
        end
      end
    end
    for (int k = 0; k < fill; k++) begin
      s = (head + k) % 64;
      p.xl = qlo[s][0]; p.xh = qhi[s][0];
      p.yl = qlo[s][1]; p.yh = qhi[s][1];
      p.zl = qlo[s][2]; p.zh = qhi[s][2];
      p.num = 6'(k);
      p.st = ST_OK;
      p.last = (k + 1 == fill);
      expect_part(p);
    end
  endtask

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    block_part_t e;
    logic [15:0] lo[3], hi[3];
    if (rst) begin
      fail_count = 0;
      parts_seen <= 0;
      errors_seen <= 0;
      expected_parts.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        lo[0] = in_ch.x_low; hi[0] = in_ch.x_high;
        lo[1] = in_ch.y_low; hi[1] = in_ch.y_high;
        lo[2] = in_ch.z_low; hi[2] = in_ch.z_high;
        bisect_extent(lo, hi, in_ch.block_count);
      end
      if (out_ch.valid && out_ch.ready) begin
        parts_seen <= parts_seen + 1;
        if (out_ch.status != ST_OK) errors_seen <= errors_seen + 1;
        if (expected_parts.size() == 0) begin
          $error("result item with no expectation pending");
          fail_count++;
        end else begin
          e = expected_parts[0];
          expected_parts.delete(0);
          compare_field("part_x_low", e.xl, out_ch.part_x_low);
          compare_field("part_x_high", e.xh, out_ch.part_x_high);
          compare_field("part_y_low", e.yl, out_ch.part_y_low);
          compare_field("part_y_high", e.yh, out_ch.part_y_high);
          compare_field("part_z_low", e.zl, out_ch.part_z_low);
          compare_field("part_z_high", e.zh, out_ch.part_z_high);
          compare_field("part_number", e.num, out_ch.part_number);
          compare_field("status", e.st, out_ch.status);
          compare_field("last_part", e.last, out_ch.last_part);
        end
      end
    end
    pending_parts = expected_parts.size();
  end
endmodule

FILE: bench/extent_bisection_partitioner_core_tb.sv
`timescale 1ns / 1ps

module extent_bisection_partitioner_core_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count, pending_parts, parts_seen, errors_seen;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_sent = 0;

  ebp_in_if  in_ch();
  ebp_out_if out_ch();

  extent_bisection_partitioner_core DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  extent_bisection_partitioner_core_checker checker_inst (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count),
    .pending_parts(pending_parts), .parts_seen(parts_seen), .errors_seen(errors_seen));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    if (cycle_count > 600000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(logic [15:0] xl, xh, yl, yh, zl, zh, logic [6:0] bc);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x_low <= xl; in_ch.x_high <= xh;
    in_ch.y_low <= yl; in_ch.y_high <= yh;
    in_ch.z_low <= zl; in_ch.z_high <= zh;
    in_ch.block_count <= bc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_parts != 0) @(posedge clk);
  endtask

  task automatic random_axis(output logic [15:0] lo, output logic [15:0] hi);
    int r;
    r = $urandom_range(9, 0);
    lo = 16'($urandom);
    if (r == 0) begin
      hi = lo;
    end else if (r == 1) begin
      lo = 16'($urandom_range(65535, 1));
      hi = lo - 16'($urandom_range(int'(lo), 1));
    end else if (r == 2) begin
      lo = 16'($urandom_range(3, 0));
      hi = 16'hFFFF - 16'($urandom_range(3, 0));
    end else begin
      hi = (lo > 16'hFFFF - 16'd200) ? 16'hFFFF : lo + 16'($urandom_range(200, 0));
    end
  endtask

  task automatic random_request();
    logic [15:0] xl, xh, yl, yh, zl, zh;
    logic [6:0] bc;
    random_axis(xl, xh);
    random_axis(yl, yh);
    random_axis(zl, zh);
    case ($urandom_range(7, 0))
      0: bc = 7'($urandom);
      1: bc = 7'($urandom_range(64, 60));
      default: bc = 7'($urandom_range(12, 1));
    endcase
    send_request(xl, xh, yl, yh, zl, zh, bc);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.x_low = '0; in_ch.x_high = '0;
    in_ch.y_low = '0; in_ch.y_high = '0;
    in_ch.z_low = '0; in_ch.z_high = '0;
    in_ch.block_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_request(0, 0, 0, 0, 0, 0, 1);
    send_request(0, 0, 0, 0, 0, 0, 0);
    send_request(0, 0, 0, 0, 0, 0, 2);
    send_request(0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 64);
    send_request(0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 7'h7F);
    send_request(0, 16'hFFFF, 5, 5, 9, 9, 65);
    send_request(16'hFFFF, 16'hFFFF, 0, 7, 0, 7, 64);
    send_request(10, 12, 0, 1, 3, 3, 6);
    send_request(10, 12, 0, 1, 3, 3, 7);
    send_request(1, 0, 0, 0, 0, 0, 1);
    send_request(0, 0, 16'hFFFF, 0, 0, 0, 1);
    send_request(0, 0, 0, 0, 16'h8000, 16'h7FFF, 1);
    send_request(1, 0, 0, 0, 0, 0, 99);
    send_request(0, 2, 0, 2, 0, 2, 27);
    send_request(0, 4, 0, 2, 0, 0, 13);
    send_request(16'hAAAA, 16'hD555, 16'h5555, 16'h5556, 0, 0, 40);
    drain_results();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 34) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 34) : 0;
      for (int i = 0; i < 29; i++) random_request();
      drain_results();
    end
    repeat (200) @(posedge clk);
    $display("Sent %0d requests; checked %0d result items, %0d of them error items.",
             requests_sent, parts_seen, errors_seen);
    if (fail_count == 0 && pending_parts == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
